/* rtl/delta_uleb128_address_list_encoder_macros.svh */
// Assertion macros for the delta ULEB128 address list encoder
`ifndef DELTA_ULEB128_ADDRESS_LIST_ENCODER_MACROS_SVH
`define DELTA_ULEB128_ADDRESS_LIST_ENCODER_MACROS_SVH

// concurrent check, masked during reset
`define DULAE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check, active during reset as well
`define DULAE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/dulae_pkg.sv */
// Types and constants shared by the delta ULEB128 address list encoder
package dulae_pkg;

   localparam int ADDR_W     = 64;
   localparam int BYTE_W     = 8;
   localparam int GROUP_BITS = 7;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CMP  = 5'b00010,
      ST_EMIT = 5'b00100,
      ST_PAD  = 5'b01000,
      ST_OOO  = 5'b10000
   } state_type;

   typedef struct packed {
      logic capture;
      logic compare;
      logic emit_data;
      logic emit_pad;
      logic emit_ooo;
   } ctrl_type;

   typedef struct packed {
      logic func;
      logic addr_eq;
      logic addr_lt;
      logic rest_last;
      logic pad_last;
      logic slot_free;
   } status_type;

endpackage

/* rtl/dulae_dpath.sv */
// Datapath: shared subtract/compare unit, 7-bit group shifter, byte counter, output register
`include "delta_uleb128_address_list_encoder_macros.svh"

module dulae_dpath #(
   parameter int ALIGN_BYTES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dulae_pkg::ctrl_type              ctrl,
   input  logic [dulae_pkg::ADDR_W-1:0]     req_tdata,
   input  logic                             req_tuser,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [dulae_pkg::ADDR_W-1:0]     csr_data,
   input  logic                             rsp_tready,
   output dulae_pkg::status_type            status,
   output logic                             rsp_tvalid,
   output logic [dulae_pkg::BYTE_W-1:0]     rsp_tdata,
   output logic                             rsp_tlast,
   output logic                             rsp_tuser
);

   localparam int CW = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
   localparam int AW = dulae_pkg::ADDR_W;
   localparam int GB = dulae_pkg::GROUP_BITS;

   logic [AW-1:0] base_ff, base_in;
   logic [AW-1:0] prev_ff, prev_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          func_ff, func_in;
   logic [AW-1:0] rest_ff, rest_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          vld_ff, vld_in;
   logic [dulae_pkg::BYTE_W-1:0] data_ff, data_in;
   logic          last_ff, last_in;
   logic          ooo_ff, ooo_in;

   logic [AW:0]   diff;
   logic [CW-1:0] cnt_inc;
   logic          rest_last;
   logic          slot_free;

   assign diff      = {1'b0, addr_ff} - {1'b0, prev_ff};
   assign cnt_inc   = (cnt_ff == CW'(ALIGN_BYTES - 1)) ? '0 : cnt_ff + CW'(1);
   assign rest_last = (rest_ff[AW-1:GB] == '0);
   assign slot_free = !vld_ff || rsp_tready;

   always_comb begin
      status.func      = func_ff;
      status.addr_eq   = (diff == '0);
      status.addr_lt   = diff[AW];
      status.rest_last = rest_last;
      status.pad_last  = (cnt_inc == '0);
      status.slot_free = slot_free;
   end

   always_comb begin
      base_in = base_ff;
      prev_in = prev_ff;
      addr_in = addr_ff;
      func_in = func_ff;
      rest_in = rest_ff;
      cnt_in  = cnt_ff;
      vld_in  = rsp_tready ? 1'b0 : vld_ff;
      data_in = data_ff;
      last_in = last_ff;
      ooo_in  = ooo_ff;
      if (ctrl.capture) begin
         addr_in = req_tdata;
         func_in = req_tuser;
      end
      if (ctrl.compare && !func_ff && !diff[AW] && (diff != '0)) begin
         rest_in = diff[AW-1:0];
         prev_in = addr_ff;
      end
      if (ctrl.emit_data) begin
         vld_in  = 1'b1;
         data_in = {!rest_last, rest_ff[GB-1:0]};
         last_in = rest_last;
         ooo_in  = 1'b0;
         rest_in = rest_ff >> GB;
         cnt_in  = cnt_inc;
      end
      if (ctrl.emit_pad) begin
         vld_in  = 1'b1;
         data_in = '0;
         last_in = (cnt_inc == '0);
         ooo_in  = 1'b0;
         cnt_in  = cnt_inc;
         if (cnt_inc == '0) begin
            prev_in = base_ff;
         end
      end
      if (ctrl.emit_ooo) begin
         vld_in  = 1'b1;
         data_in = '0;
         last_in = 1'b1;
         ooo_in  = 1'b1;
      end
      if (csr_valid && csr_ready) begin
         base_in = csr_data;
         prev_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         prev_ff <= '0;
         cnt_ff  <= '0;
         vld_ff  <= 1'b0;
      end else begin
         base_ff <= base_in;
         prev_ff <= prev_in;
         cnt_ff  <= cnt_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      func_ff <= func_in;
      rest_ff <= rest_in;
      data_ff <= data_in;
      last_ff <= last_in;
      ooo_ff  <= ooo_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = ooo_ff;

   `DULAE_ASSERT(a_emit_slot, clock, reset, (ctrl.emit_data || ctrl.emit_pad || ctrl.emit_ooo) |-> slot_free, "word issued into a full output register")
   `DULAE_ASSERT(a_ooo_shape, clock, reset, (vld_ff && ooo_ff) |-> (last_ff && data_ff == '0), "out of order word must be a lone zero word")
   `DULAE_ASSERT(a_cnt_range, clock, reset, cnt_ff <= CW'(ALIGN_BYTES - 1), "byte count out of range")
   `DULAE_ASSERT(a_pad_zero, clock, reset, (ctrl.emit_pad && status.pad_last) |=> (cnt_ff == '0 && prev_ff == base_ff), "list end did not restore start state")

endmodule

/* rtl/dulae_fsm.sv */
// Sequencer: accepts one word, runs compare, then issues one output word per free slot
`include "delta_uleb128_address_list_encoder_macros.svh"

module dulae_fsm (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  dulae_pkg::status_type status,
   output dulae_pkg::ctrl_type   ctrl
);

   dulae_pkg::state_type state_ff, state_in;

   assign req_tready = (state_ff == dulae_pkg::ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      ctrl           = '0;
      case (state_ff)
         dulae_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               ctrl.capture = 1'b1;
               state_in     = dulae_pkg::ST_CMP;
            end
         end
         dulae_pkg::ST_CMP: begin
            ctrl.compare = 1'b1;
            if (status.func) begin
               state_in = dulae_pkg::ST_PAD;
            end else if (status.addr_eq) begin
               state_in = dulae_pkg::ST_IDLE;
            end else if (status.addr_lt) begin
               state_in = dulae_pkg::ST_OOO;
            end else begin
               state_in = dulae_pkg::ST_EMIT;
            end
         end
         dulae_pkg::ST_EMIT: begin
            if (status.slot_free) begin
               ctrl.emit_data = 1'b1;
               if (status.rest_last) begin
                  state_in = dulae_pkg::ST_IDLE;
               end
            end
         end
         dulae_pkg::ST_PAD: begin
            if (status.slot_free) begin
               ctrl.emit_pad = 1'b1;
               if (status.pad_last) begin
                  state_in = dulae_pkg::ST_IDLE;
               end
            end
         end
         dulae_pkg::ST_OOO: begin
            if (status.slot_free) begin
               ctrl.emit_ooo = 1'b1;
               state_in      = dulae_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dulae_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dulae_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `DULAE_ASSERT(a_cmp_follows, clock, reset, ctrl.capture |=> (state_ff == dulae_pkg::ST_CMP), "compare must follow accept")
   `DULAE_ASSERT(a_one_emit, clock, reset, $onehot0({ctrl.emit_data, ctrl.emit_pad, ctrl.emit_ooo}), "more than one word source")

endmodule

/* rtl/delta_uleb128_address_list_encoder.sv */
// Top level: delta ULEB128 address list encoder
// Flow: the accepted word is registered, compared in ST_CMP, then its output words pass through the output register.
// An address gives n = 1..10 ULEB128 bytes, one per cycle while the output register is free,
// through the shared 7-bit group shifter; equal addresses give no byte, out of order one zero word.
// End of list gives terminator/padding bytes (up to ALIGN_BYTES).
// Synchronous reset: load base, previous address and byte count cleared, output empty.
module delta_uleb128_address_list_encoder #(
   parameter int ALIGN_BYTES = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dulae_pkg::ADDR_W-1:0]  req_tdata,   // [63:0] address
   input  logic                          req_tuser,   // [0] func (1 = end of list)
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [dulae_pkg::BYTE_W-1:0]  rsp_tdata,   // [7:0] out_byte
   output logic                          rsp_tlast,
   output logic                          rsp_tuser,   // [0] out_of_order
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dulae_pkg::ADDR_W-1:0]  csr_data
);

   dulae_pkg::ctrl_type   ctrl;
   dulae_pkg::status_type status;

   assign csr_ready = 1'b1;

   dulae_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .ctrl       (ctrl)
   );

   dulae_dpath #(
      .ALIGN_BYTES (ALIGN_BYTES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
